// File: hw/rtl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg: shared types and constants for the ordered key/value table
// Opcodes, fixed port field widths and the per-cell command word.
// ----------------------------------------------------------------------------
package okvt_pkg;

  localparam int OPC_W = 3;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  localparam logic [OPC_W-1:0] OP_CONTAINS = 3'd0;
  localparam logic [OPC_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OPC_W-1:0] OP_UPDATE   = 3'd2;
  localparam logic [OPC_W-1:0] OP_UPSERT   = 3'd3;
  localparam logic [OPC_W-1:0] OP_ERASE    = 3'd4;
  localparam logic [OPC_W-1:0] OP_GET_KEY  = 3'd5;
  localparam logic [OPC_W-1:0] OP_GET_POS  = 3'd6;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic match;  // compare stored key, latch hit and position select
    logic ins;    // cell at the tail slot loads the new word
    logic upd;    // matching cell loads the new value
    logic ers;    // cells at or above the erase point take the neighbor's word
  } cell_cmd_t;

endpackage

// File: hw/rtl/okvt_in_if.sv
// ----------------------------------------------------------------------------
// okvt_in_if: request channel of the ordered key/value table
// Valid/ready handshake carrying opcode, key, value and position.
// ----------------------------------------------------------------------------
interface okvt_in_if;
  logic                          valid;
  logic                          ready;
  logic [okvt_pkg::OPC_W-1:0]    opcode;
  logic [okvt_pkg::KEY_W-1:0]    key;
  logic [okvt_pkg::VAL_W-1:0]    value;
  logic [okvt_pkg::POS_W-1:0]    position;

  modport source (output valid, opcode, key, value, position, input ready);
  modport sink   (input valid, opcode, key, value, position, output ready);
endinterface

// File: hw/rtl/okvt_out_if.sv
// ----------------------------------------------------------------------------
// okvt_out_if: result channel of the ordered key/value table
// Valid/ready handshake carrying status, key, value and entry count.
// ----------------------------------------------------------------------------
interface okvt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [okvt_pkg::KEY_W-1:0]    key_out;
  logic [okvt_pkg::VAL_W-1:0]    value_out;
  logic [okvt_pkg::CNT_W-1:0]    entry_count;
  logic                          is_empty;

  modport source (output valid, ok, key_out, value_out, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, ok, key_out, value_out, entry_count, is_empty,
                  output ready);
endinterface

// File: hw/rtl/ordered_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_unit: insertion-ordered associative key/value table
// Unique keys in a chain of cells; contains, insert, update, upsert, erase,
// get by key and get by position, one result word per request word.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request words (opcode, key, value, position), valid/ready.
//   rsp  - one result word per request (ok, key_out, value_out, entry_count,
//          is_empty), valid/ready.
//   cfg_we / cfg_wdata - write capacity_limit; write only while idle.
// Timing: each request passes match (every cell compares its key at once),
//   resolve (hit/position bits are gathered into one index and read word)
//   and act (cells insert, update or shift down on erase, result is
//   registered). A new request is taken in the act cycle, so the block
//   accepts the next request while it finishes the current one.
// Stall: the result sits in an output register; the next request is still
//   taken while it waits, but its act cycle holds until the slot drains.
// Reset: entry count clears to zero and capacity_limit returns to 64. The
//   cell storage is not cleared; slots at or above the count are never read.
// ----------------------------------------------------------------------------
module ordered_key_value_table_unit #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  okvt_in_if.sink                     req,
  okvt_out_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [okvt_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_MATCH   = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;
  localparam logic [1:0] S_ACT     = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // capacity register and live entry count
  logic [okvt_pkg::CNT_W-1:0] cap;
  logic [okvt_pkg::CNT_W-1:0] count;
  logic [okvt_pkg::CNT_W-1:0] count_next;
  logic [okvt_pkg::CNT_W-1:0] eff_lim;

  // latched request
  logic [okvt_pkg::OPC_W-1:0] op_q;
  logic [okvt_pkg::KEY_W-1:0] key_q;
  logic [okvt_pkg::VAL_W-1:0] val_q;
  logic [okvt_pkg::POS_W-1:0] pos_q;

  logic [KEY_BITS-1:0]   key_bus;
  logic [VALUE_BITS-1:0] val_bus;

  // cell chain
  okvt_pkg::cell_cmd_t   cmd;
  logic [KEY_BITS-1:0]   c_key [ENTRIES];
  logic [VALUE_BITS-1:0] c_val [ENTRIES];
  logic [ENTRIES-1:0]    c_hit;
  logic [ENTRIES-1:0]    c_at;

  // gathered match results
  logic                  found_c, found;
  logic [IW-1:0]         hit_idx_c, hit_idx;
  logic [VALUE_BITS-1:0] hit_val_c, hit_val;
  logic                  at_any_c, at_any;
  logic [KEY_BITS-1:0]   at_key_c, at_key;
  logic [VALUE_BITS-1:0] at_val_c, at_val;

  logic accept;
  logic out_free;
  logic act_go;
  logic full;
  logic ok_c;
  logic do_ins, do_upd, do_ers;
  logic [okvt_pkg::KEY_W-1:0] kout_c;
  logic [okvt_pkg::VAL_W-1:0] vout_c;

  assign out_free = !rsp.valid || rsp.ready;
  assign act_go   = (state == S_ACT) && out_free;
  assign req.ready = (state == S_IDLE) || act_go;
  assign accept   = req.valid && req.ready;

  assign key_bus = KEY_BITS'(key_q);
  assign val_bus = VALUE_BITS'(val_q);

  // saturate the limit at the physical depth
  assign eff_lim = (int'(cap) > ENTRIES) ? okvt_pkg::CNT_W'(ENTRIES) : cap;
  assign full    = count >= eff_lim;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_MATCH;
      S_MATCH:   state_next = S_RESOLVE;
      S_RESOLVE: state_next = S_ACT;
      S_ACT: begin
        if (act_go) state_next = accept ? S_MATCH : S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap   <= okvt_pkg::CAP_RESET;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) cap <= cfg_wdata;
      if (act_go) count <= count_next;
    end
  end

  // hold the request word for the duration of its work
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.opcode;
      key_q <= req.key;
      val_q <= req.value;
      pos_q <= req.position;
    end
  end

  assign cmd.match = (state == S_MATCH);
  assign cmd.ins   = act_go && do_ins;
  assign cmd.upd   = act_go && do_upd;
  assign cmd.ers   = act_go && do_ers;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nk;
    logic [VALUE_BITS-1:0] nv;
    // top cell refills from itself; it falls at or above the count after erase
    if (i == ENTRIES - 1) begin : g_top
      assign nk = c_key[i];
      assign nv = c_val[i];
    end else begin : g_mid
      assign nk = c_key[i+1];
      assign nv = c_val[i+1];
    end
    okvt_cell #(
      .IDX        (i),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IW         (IW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .key_bus  (key_bus),
      .val_bus  (val_bus),
      .pos      (pos_q),
      .count    (count),
      .erase_at (hit_idx),
      .nxt_key  (nk),
      .nxt_val  (nv),
      .key_q    (c_key[i]),
      .val_q    (c_val[i]),
      .hit      (c_hit[i]),
      .at       (c_at[i])
    );
  end

  // Gather the one-hot hit and position flags into an index and read words.
  // Keys are unique among live cells, so at most one hit is set.
  always_comb begin
    found_c   = 1'b0;
    hit_idx_c = '0;
    hit_val_c = '0;
    at_any_c  = 1'b0;
    at_key_c  = '0;
    at_val_c  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      found_c   = found_c | c_hit[i];
      hit_idx_c = hit_idx_c | (c_hit[i] ? IW'(i) : '0);
      hit_val_c = hit_val_c | (c_hit[i] ? c_val[i] : '0);
      at_any_c  = at_any_c | c_at[i];
      at_key_c  = at_key_c | (c_at[i] ? c_key[i] : '0);
      at_val_c  = at_val_c | (c_at[i] ? c_val[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESOLVE) begin
      found   <= found_c;
      hit_idx <= hit_idx_c;
      hit_val <= hit_val_c;
      at_any  <= at_any_c;
      at_key  <= at_key_c;
      at_val  <= at_val_c;
    end
  end

  // Decide the operation's effect from the gathered match.
  always_comb begin
    ok_c       = 1'b0;
    do_ins     = 1'b0;
    do_upd     = 1'b0;
    do_ers     = 1'b0;
    count_next = count;
    kout_c     = key_q;
    vout_c     = '0;
    case (op_q)
      okvt_pkg::OP_CONTAINS: ok_c = found;
      okvt_pkg::OP_INSERT: begin
        if (!found && !full) begin
          do_ins     = 1'b1;
          ok_c       = 1'b1;
          count_next = count + 1'b1;
        end
      end
      okvt_pkg::OP_UPDATE: begin
        do_upd = found;
        ok_c   = found;
      end
      okvt_pkg::OP_UPSERT: begin
        if (found) begin
          do_upd = 1'b1;
          ok_c   = 1'b1;
        end else if (!full) begin
          do_ins     = 1'b1;
          ok_c       = 1'b1;
          count_next = count + 1'b1;
        end
      end
      okvt_pkg::OP_ERASE: begin
        if (found) begin
          do_ers     = 1'b1;
          ok_c       = 1'b1;
          count_next = count - 1'b1;
        end
      end
      okvt_pkg::OP_GET_KEY: begin
        ok_c = found;
        if (found) vout_c = okvt_pkg::VAL_W'(hit_val);
      end
      okvt_pkg::OP_GET_POS: begin
        // at_any is only set for positions that exist in the chain
        if (at_any && ({1'b0, pos_q} < count)) begin
          ok_c   = 1'b1;
          kout_c = okvt_pkg::KEY_W'(at_key);
          vout_c = okvt_pkg::VAL_W'(at_val);
        end
      end
      default: ok_c = 1'b0;
    endcase
  end

  // output register: load on act, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (act_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act_go) begin
      rsp.ok          <= ok_c;
      rsp.key_out     <= kout_c;
      rsp.value_out   <= vout_c;
      rsp.entry_count <= count_next;
      rsp.is_empty    <= (count_next == '0);
    end
  end

endmodule

// File: hw/rtl/okvt_cell.sv
// ----------------------------------------------------------------------------
// okvt_cell: one slot of the table chain
// Holds one key/value word, matches it against the broadcast key and shifts
// in its upper neighbor's word when the entry at or below it is erased.
// ----------------------------------------------------------------------------
module okvt_cell #(
  parameter int IDX        = 0,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int IW         = 6
) (
  input  logic                        clk,
  input  okvt_pkg::cell_cmd_t         cmd,
  input  logic [KEY_BITS-1:0]         key_bus,
  input  logic [VALUE_BITS-1:0]       val_bus,
  input  logic [okvt_pkg::POS_W-1:0]  pos,
  input  logic [okvt_pkg::CNT_W-1:0]  count,
  input  logic [IW-1:0]               erase_at,
  input  logic [KEY_BITS-1:0]         nxt_key,
  input  logic [VALUE_BITS-1:0]       nxt_val,
  output logic [KEY_BITS-1:0]         key_q,
  output logic [VALUE_BITS-1:0]       val_q,
  output logic                        hit,
  output logic                        at
);

  logic live;
  logic tail;
  logic above;

  assign live  = int'(count) > IDX;
  assign tail  = int'(count) == IDX;
  assign above = IDX >= int'(erase_at);

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit <= live && (key_q == key_bus);
      at  <= int'(pos) == IDX;
    end
    if (cmd.ins && tail) begin
      key_q <= key_bus;
      val_q <= val_bus;
    end else if (cmd.upd && hit) begin
      val_q <= val_bus;
    end else if (cmd.ers && above) begin
      key_q <= nxt_key;
      val_q <= nxt_val;
    end
  end

endmodule

// File: hw/rtl/okvt_checker.sv
// ----------------------------------------------------------------------------
// okvt_checker: port-level checks for the ordered key/value table
// Watches the request and result handshakes and the reported entry count.
// ----------------------------------------------------------------------------
module okvt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        ok,
  input logic [okvt_pkg::CNT_W-1:0]  entry_count,
  input logic                        is_empty
);

  logic [1:0]                 pending;
  logic [okvt_pkg::CNT_W-1:0] last_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_count <= '0;
    end else begin
      pending <= pending + 2'((req_valid && req_ready))
                         - 2'((rsp_valid && rsp_ready));
      if (rsp_valid && rsp_ready) last_count <= entry_count;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(ok) && $stable(entry_count) && $stable(is_empty))
    else $error("result word changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count == last_count) || (entry_count == last_count + 1'b1)
                  || (entry_count == last_count - 1'b1))
    else $error("entry count moved by more than one between results");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != '0)
    else $error("result without an outstanding request");

endmodule

bind ordered_key_value_table_unit okvt_checker u_okvt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .ok          (rsp.ok),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty)
);

// File: test/ordered_key_value_table_unit_check.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_unit_check: result checker for the key/value table
// Watches the request, result and capacity ports, keeps a shadow copy of the
// table, predicts one result word per accepted request and compares each
// accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module ordered_key_value_table_unit_check import okvt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  okvt_in_if               req,
  okvt_out_if              rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key_out;
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } table_reply_t;

  logic [KEY_W-1:0] shadow_keys   [SLOTS];
  logic [VAL_W-1:0] shadow_values [SLOTS];
  int               shadow_count = 0;
  logic [CNT_W-1:0] shadow_limit = CAP_RESET;
  table_reply_t     replies_due [$];
  int               mismatch_total = 0;
  int               due_total = 0;

  assign fail_count  = mismatch_total;
  assign results_due = due_total;

  function automatic int slot_of(input logic [KEY_W-1:0] k);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] == k) return i;
    return shadow_count;
  endfunction

  // Append at the tail; refuse when full (limit saturates at SLOTS) or present.
  function automatic bit append_entry(input logic [KEY_W-1:0] k,
                                      input logic [VAL_W-1:0] v);
    int cap;
    cap = (shadow_limit > SLOTS) ? SLOTS : int'(shadow_limit);
    if (shadow_count >= cap || slot_of(k) < shadow_count) return 1'b0;
    shadow_keys[shadow_count]   = k;
    shadow_values[shadow_count] = v;
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic bit rewrite_value(input logic [KEY_W-1:0] k,
                                       input logic [VAL_W-1:0] v);
    int p;
    p = slot_of(k);
    if (p >= shadow_count) return 1'b0;
    shadow_values[p] = v;
    return 1'b1;
  endfunction

  function automatic table_reply_t predict_reply(input logic [OPC_W-1:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [VAL_W-1:0] v,
                                                 input logic [POS_W-1:0] pos);
    table_reply_t r;
    int p;
    r.ok        = 1'b0;
    r.key_out   = k;
    r.value_out = '0;
    case (op)
      OP_CONTAINS: r.ok = slot_of(k) < shadow_count;
      OP_INSERT:   r.ok = append_entry(k, v);
      OP_UPDATE:   r.ok = rewrite_value(k, v);
      OP_UPSERT: begin
        r.ok = rewrite_value(k, v);
        if (!r.ok) r.ok = append_entry(k, v);
      end
      OP_ERASE: begin
        p = slot_of(k);
        if (p < shadow_count) begin
          // close the gap so insertion order is kept
          for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i+1];
            shadow_values[i] = shadow_values[i+1];
          end
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_GET_KEY: begin
        p = slot_of(k);
        if (p < shadow_count) begin
          r.value_out = shadow_values[p];
          r.ok        = 1'b1;
        end
      end
      OP_GET_POS: begin
        if (int'(pos) < shadow_count) begin
          r.key_out   = shadow_keys[pos];
          r.value_out = shadow_values[pos];
          r.ok        = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  function automatic void compare_field(input string field,
                                        input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      shadow_count = 0;
      shadow_limit = CAP_RESET;
      replies_due.delete();
    end else begin
      // retire first: a result word never belongs to a request taken this edge
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $error("result word with no request outstanding");
          mismatch_total++;
        end else begin
          want = replies_due.pop_front();
          compare_field("ok",          want.ok,          rsp.ok);
          compare_field("key_out",     want.key_out,     rsp.key_out);
          compare_field("value_out",   want.value_out,   rsp.value_out);
          compare_field("entry_count", want.entry_count, rsp.entry_count);
          compare_field("is_empty",    want.is_empty,    rsp.is_empty);
        end
      end
      if (cfg_we) shadow_limit = cfg_wdata;
      if (req.valid && req.ready)
        replies_due.push_back(predict_reply(req.opcode, req.key, req.value,
                                            req.position));
    end
    due_total <= replies_due.size();
  end

endmodule

// File: test/ordered_key_value_table_unit_test.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_unit_test: testbench for the ordered key/value table
// Drives a directed sequence over the corner cases, then random phases with
// varied capacity, key-pool size and handshake pressure; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module ordered_key_value_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import okvt_pkg::*;

  // Opcode 7 is outside the defined set; the block must leave the table alone.
  localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;
  // The slowest legal run of ~780 words stays well under this limit.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE    = 96;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               results_due;
  int               idle_pct    = 0;
  int               stall_pct   = 0;
  int               cycle_count = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  okvt_in_if  req_ch();
  okvt_out_if rsp_ch();

  ordered_key_value_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ordered_key_value_table_unit_check table_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always #6ns clk = ~clk;

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: stall at the rate the current phase asks for.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one request word at a falling edge, with random idle cycles in
  // front of it, and hold it until the block takes it. Valid stays high on
  // return so back-to-back words never drop it.
  task automatic send_word(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v, input logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.key      <= k;
    req_ch.value    <= v;
    req_ch.position <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid, let every outstanding result drain, then write the limit.
  task automatic write_capacity(input logic [CNT_W-1:0] limit);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    cfg_wdata <= limit;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase. grow/shrink are the percentages of insert-type and
  // erase words; the rest are lookups, updates and the odd unused opcode.
  // span picks how many pool keys are in play, which sets how full it gets.
  task automatic run_phase(input logic [CNT_W-1:0] limit, input int words,
                           input int grow, input int shrink, input int span,
                           input int idle, input int stall);
    logic [OPC_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] pos;
    int               pick;
    write_capacity(limit);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (words) begin
      pick = $urandom_range(99);
      if (pick < grow) begin
        op = ($urandom_range(4) < 3) ? OP_INSERT : OP_UPSERT;
      end else if (pick < grow + shrink) begin
        op = OP_ERASE;
      end else begin
        pick = $urandom_range(20);
        op = (pick < 5)  ? OP_CONTAINS :
             (pick < 10) ? OP_UPDATE   :
             (pick < 15) ? OP_GET_KEY  :
             (pick < 20) ? OP_GET_POS  : OP_UNUSED;
      end
      // mostly pool keys so lookups hit; now and then a fresh random key
      k   = ($urandom_range(9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(span - 1)];
      // favor low positions so small tables still see hits
      pos = ($urandom_range(1) == 1) ? POS_W'($urandom_range(63)) : POS_W'($urandom_range(7));
      send_word(op, k, VAL_W'($urandom), pos);
    end
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.opcode   = '0;
    req_ch.key      = '0;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, duplicates, gaps, bad positions.
    send_word(OP_CONTAINS, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(OP_GET_POS,  32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(OP_ERASE,    32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    send_word(OP_UPDATE,   32'h0000_0000, 32'h0000_0001, 6'd0);
    send_word(OP_INSERT,   32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
    send_word(OP_INSERT,   32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    // insert of a present key must fail and leave the value alone
    send_word(OP_INSERT,   32'h0000_0000, 32'h1234_5678, 6'd0);
    send_word(OP_UPDATE,   32'h0000_0000, 32'h1234_5678, 6'd0);
    send_word(OP_UPSERT,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 6'd0);
    send_word(OP_UPSERT,   32'h5A5A_5A5A, 32'h0000_0001, 6'd0);
    send_word(OP_GET_KEY,  32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    send_word(OP_GET_KEY,  32'h0000_0007, 32'h0000_0000, 6'd0);
    send_word(OP_GET_POS,  32'h0000_7777, 32'h0000_0000, 6'd2);
    // positions at and past the count must fail and echo the key
    send_word(OP_GET_POS,  32'h8000_0000, 32'h0000_0000, 6'd63);
    send_word(OP_GET_POS,  32'h0000_0001, 32'h0000_0000, 6'd3);
    // erase the head: the rest shifts down in order
    send_word(OP_ERASE,    32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(OP_GET_POS,  32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(OP_CONTAINS, 32'h0000_0000, 32'h0000_0000, 6'd0);
    send_word(OP_UNUSED,   32'hDEAD_BEEF, 32'hFFFF_FFFF, 6'd63);

    // Shrink the limit below the live count: inserts fail until erases bring the count under it, the rest works.
    write_capacity(7'd1);
    send_word(OP_INSERT,   32'h0000_0010, 32'h0000_00AA, 6'd0);
    send_word(OP_UPSERT,   32'h0000_0010, 32'h0000_00BB, 6'd0);
    send_word(OP_UPSERT,   32'hFFFF_FFFF, 32'h0F0F_0F0F, 6'd0);
    send_word(OP_ERASE,    32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
    send_word(OP_INSERT,   32'h0000_0010, 32'h0000_00CC, 6'd0);
    send_word(OP_ERASE,    32'h5A5A_5A5A, 32'h0000_0000, 6'd0);
    send_word(OP_INSERT,   32'h0000_0010, 32'h0000_00DD, 6'd0);
    send_word(OP_CONTAINS, 32'h0000_0010, 32'h0000_0000, 6'd0);

    // Random phases: limit, words, grow %, shrink %, key span, idle %, stall %.
    run_phase(7'd64,  120, 60, 10, 96, 0,  0);   // fill to the top
    run_phase(7'd127, 100, 30, 30, 96, 49, 0);   // limit saturates at the depth
    run_phase(7'd1,   80,  20, 40, 96, 0,  49);  // limit far below the count
    run_phase(7'd0,   60,  40, 20, 16, 36, 36);  // every insert fails
    run_phase(CNT_W'($urandom_range(63, 2)),  110, 45, 20, 48, 0,  0);
    run_phase(CNT_W'($urandom_range(127, 1)), 100, 35, 30, 16, 49, 0);
    run_phase(7'd64,  100, 55, 15, 96, 0,  49);
    run_phase(CNT_W'($urandom_range(127, 0)), 80,  30, 30, 8,  36, 36);

    // Drain: drop valid, wait for the last result, then let the bench settle.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_in_if.sv
hw/rtl/okvt_out_if.sv
hw/rtl/okvt_cell.sv
hw/rtl/ordered_key_value_table_unit.sv
hw/rtl/okvt_checker.sv
test/ordered_key_value_table_unit_check.sv
test/ordered_key_value_table_unit_test.sv
